/* sv/oult_pkg.sv */
`timescale 1ns / 1ps

package oult_pkg;

  localparam int ValueW = 32;
  localparam int PosW   = 5;
  localparam int CountW = 5;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_DUP      = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_TAKE_LOWER = 2'd2,
    OP_TAKE_UPPER = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_APPLY = 2'd2
  } state_t;

endpackage

/* sv/oult_cell.sv */
`timescale 1ns / 1ps

module oult_cell (
  input  logic                          clk,
  input  oult_pkg::cell_op_t            op,
  input  logic [oult_pkg::ValueW-1:0]   key,
  input  logic [oult_pkg::ValueW-1:0]   lower_val,
  input  logic [oult_pkg::ValueW-1:0]   upper_val,
  input  logic                          in_list,
  output logic [oult_pkg::ValueW-1:0]   entry,
  output logic                          match
);

  logic [oult_pkg::ValueW-1:0] entry_r;
  logic [oult_pkg::ValueW-1:0] entry_nxt;
  logic                        match_r;

  always_comb begin
    unique case (op)
      oult_pkg::OP_HOLD:       entry_nxt = entry_r;
      oult_pkg::OP_LOAD:       entry_nxt = key;
      oult_pkg::OP_TAKE_LOWER: entry_nxt = lower_val;
      oult_pkg::OP_TAKE_UPPER: entry_nxt = upper_val;
      default:                 entry_nxt = entry_r;
    endcase
  end

  // Entries above the fill level may hold stale data, so they never match.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= in_list && (entry_r == key);
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

/* sv/ordered_unique_list_table.sv */
`timescale 1ns / 1ps
// Ordered list of distinct 32-bit values held in a row of CAPACITY cells.
// Input channel in_*: one word per command (lookup, insert at position,
// remove by value). Output channel out_*: one result word per command with
// status, whether the value was present beforehand, and the entry count.
// A command goes through two steps inside the block: in the first every cell
// compares its entry with the value and registers a hit; in the second the
// hits are reduced to a slot index, the command is decided, and the affected
// cells shift or load together while the result goes to the output register.
// The result is registered. A new command is accepted in the same cycle as the
// previous one is applied, but not during its compare step. The compare/apply
// loop keeps commands apart: each command must see the list left by the one
// before.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. If the receiver stalls, the result waits in the output register;
// the next command is taken in, compared, and then holds in its apply cycle
// until the output register is free, with in_tready low meanwhile.

module ordered_unique_list_table #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], position[6:2], item_value[38:7], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[2:0], was_present[3], entry_count[8:4], zero pad
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > oult_pkg::PosW) ? CW : oult_pkg::PosW;
  localparam int EW = (CW > oult_pkg::CountW) ? CW : oult_pkg::CountW;

  oult_pkg::state_t state_r, state_nxt;

  logic [1:0]                  cmd_r;
  logic [oult_pkg::PosW-1:0]   pos_r;
  logic [oult_pkg::ValueW-1:0] val_r;
  logic [CW-1:0]               occ_r, occ_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [15:0]                 out_tdata_r;

  logic in_acc;
  logic apply_go;

  logic [oult_pkg::ValueW-1:0] entry   [CAPACITY];
  logic [CAPACITY-1:0]         match;
  oult_pkg::cell_op_t          cell_op [CAPACITY];

  logic                 present;
  logic [IW-1:0]        slot;
  logic                 pos_bad;
  logic                 full;
  logic                 do_ins;
  logic                 do_rem;
  oult_pkg::status_t    status;
  logic [EW-1:0]        count_wide;

  assign in_acc = in_tvalid && in_tready;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    in_tready = 1'b0;
    apply_go  = 1'b0;
    unique case (state_r)
      oult_pkg::S_IDLE:  in_tready = 1'b1;
      oult_pkg::S_MATCH: in_tready = 1'b0;
      oult_pkg::S_APPLY: begin
        apply_go  = !out_valid_r || out_tready;
        in_tready = apply_go;
      end
      default: in_tready = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oult_pkg::S_IDLE: begin
        if (in_acc) state_nxt = oult_pkg::S_MATCH;
      end
      oult_pkg::S_MATCH: state_nxt = oult_pkg::S_APPLY;
      oult_pkg::S_APPLY: begin
        if (apply_go) state_nxt = in_acc ? oult_pkg::S_MATCH : oult_pkg::S_IDLE;
      end
      default: state_nxt = oult_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------- decision
  always_comb begin
    slot = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (match[k]) slot = slot | IW'(k);
    end
  end

  assign present = |match;
  assign pos_bad = PW'(pos_r) > PW'(occ_r);
  assign full    = occ_r == CW'(CAPACITY);

  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    status = present ? oult_pkg::STAT_OK : oult_pkg::STAT_NOTFOUND;
    if (cmd_r == oult_pkg::CMD_INSERT) begin
      priority if (pos_bad) begin
        status = oult_pkg::STAT_RANGE;
      end else if (present) begin
        status = oult_pkg::STAT_DUP;
      end else if (full) begin
        status = oult_pkg::STAT_FULL;
      end else begin
        status = oult_pkg::STAT_OK;
        do_ins = apply_go;
      end
    end else if (cmd_r == oult_pkg::CMD_REMOVE) begin
      do_rem = present && apply_go;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (do_ins) occ_nxt = occ_r + CW'(1);
    else if (do_rem) occ_nxt = occ_r - CW'(1);
  end

  // The reported count wraps modulo 32 when the capacity is large.
  assign count_wide = EW'(occ_nxt);

  // ------------------------------------------------------------- cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [oult_pkg::ValueW-1:0] lower_val;
    logic [oult_pkg::ValueW-1:0] upper_val;

    if (k == 0) begin : g_first
      assign lower_val = entry[k];
    end else begin : g_mid_lo
      assign lower_val = entry[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign upper_val = entry[k];
    end else begin : g_mid_hi
      assign upper_val = entry[k+1];
    end

    always_comb begin
      cell_op[k] = oult_pkg::OP_HOLD;
      if (do_ins) begin
        priority if (PW'(k) == PW'(pos_r)) cell_op[k] = oult_pkg::OP_LOAD;
        else if (PW'(k) > PW'(pos_r))      cell_op[k] = oult_pkg::OP_TAKE_LOWER;
        else                               cell_op[k] = oult_pkg::OP_HOLD;
      end else if (do_rem) begin
        if (IW'(k) >= slot) cell_op[k] = oult_pkg::OP_TAKE_UPPER;
      end
    end

    oult_cell u_cell (
      .clk       (clk),
      .op        (cell_op[k]),
      .key       (val_r),
      .lower_val (lower_val),
      .upper_val (upper_val),
      .in_list   (CW'(k) < occ_r),
      .entry     (entry[k]),
      .match     (match[k])
    );
  end

  // --------------------------------------------------------- registers
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply_go) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oult_pkg::S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tdata[1:0];
      pos_r <= in_tdata[6:2];
      val_r <= in_tdata[38:7];
    end
    if (apply_go) begin
      out_tdata_r <= {7'd0, count_wide[oult_pkg::CountW-1:0], present, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // -------------------------------------------------------- assertions
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == oult_pkg::S_APPLY |-> $onehot0(match))
    else $error("value found in more than one cell");

  a_match_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == oult_pkg::S_MATCH |=> state_r == oult_pkg::S_APPLY)
    else $error("compare cycle not followed by apply");

  a_occ_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    !apply_go |=> $stable(occ_r))
    else $error("entry count changed outside apply");

  a_no_accept_in_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == oult_pkg::S_MATCH |-> !in_tready)
    else $error("word accepted during compare cycle");

endmodule

/* tb/sv/ordered_unique_list_table_tb.sv */
`timescale 1ns / 1ps

module ordered_unique_list_table_tb;
  import oult_pkg::*;

  localparam int Capacity = 16;
  localparam int PoolSize = 20;
  localparam int ItemsPerPhase = 435;

  typedef struct packed {
    status_t     status;
    logic        present;
    logic [4:0]  count;
  } list_result_t;

  typedef struct packed {
    cmd_t         cmd;
    logic [4:0]   pos;
    logic [31:0]  value;
    logic         typed;
    list_result_t result;
  } directed_row_t;

  // Rows with typed = 1 carry their own expected result; the others use the predictor.
  localparam directed_row_t DirectedRows [19] = '{
    '{CMD_LOOKUP, 5'd0,  32'h0000_0000, 1'b1, '{STAT_NOTFOUND, 1'b0, 5'd0}},
    '{CMD_REMOVE, 5'd0,  32'h8000_0000, 1'b1, '{STAT_NOTFOUND, 1'b0, 5'd0}},
    '{CMD_INSERT, 5'd1,  32'h0000_0005, 1'b1, '{STAT_RANGE,    1'b0, 5'd0}},
    '{CMD_INSERT, 5'd31, 32'h0000_0005, 1'b1, '{STAT_RANGE,    1'b0, 5'd0}},
    '{CMD_INSERT, 5'd0,  32'h8000_0000, 1'b1, '{STAT_OK,       1'b0, 5'd1}},
    '{CMD_INSERT, 5'd0,  32'h8000_0000, 1'b1, '{STAT_DUP,      1'b1, 5'd1}},
    '{CMD_INSERT, 5'd1,  32'h7fff_ffff, 1'b1, '{STAT_OK,       1'b0, 5'd2}},
    '{CMD_INSERT, 5'd0,  32'hffff_ffff, 1'b1, '{STAT_OK,       1'b0, 5'd3}},
    '{CMD_INSERT, 5'd1,  32'h0000_0000, 1'b1, '{STAT_OK,       1'b0, 5'd4}},
    '{CMD_INSERT, 5'd2,  32'h8000_0000, 1'b1, '{STAT_DUP,      1'b1, 5'd4}},
    '{CMD_INSERT, 5'd9,  32'h8000_0000, 1'b1, '{STAT_RANGE,    1'b1, 5'd4}},
    '{CMD_LOOKUP, 5'd31, 32'h7fff_ffff, 1'b0, '0},
    '{CMD_SPARE,  5'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_SPARE,  5'd21, 32'h1234_5678, 1'b0, '0},
    '{CMD_REMOVE, 5'd10, 32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE, 5'd0,  32'hffff_ffff, 1'b0, '0},
    '{CMD_LOOKUP, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE, 5'd0,  32'h7fff_ffff, 1'b0, '0},
    '{CMD_REMOVE, 5'd0,  32'h8000_0000, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  logic [31:0]  list_store [Capacity];
  int           list_count = 0;
  logic [31:0]  value_pool [PoolSize];
  list_result_t pending_results [$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  bit           growing = 1'b1;

  ordered_unique_list_table #(.CAPACITY(Capacity)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Applies one command to the shadow list and returns what the block should report.
  function automatic list_result_t apply_list_command(cmd_t c, logic [4:0] pos,
                                                      logic [31:0] v);
    list_result_t res;
    int slot;
    int k;
    slot = list_count;
    for (k = list_count - 1; k >= 0; k--) begin
      if (list_store[k] == v) slot = k;
    end
    res.present = (slot < list_count);
    if (c == CMD_INSERT) begin
      if (pos > list_count) begin
        res.status = STAT_RANGE;
      end else if (res.present) begin
        res.status = STAT_DUP;
      end else if (list_count >= Capacity) begin
        res.status = STAT_FULL;
      end else begin
        for (k = list_count; k > pos; k--) list_store[k] = list_store[k - 1];
        list_store[pos] = v;
        list_count++;
        res.status = STAT_OK;
      end
    end else if (c == CMD_REMOVE) begin
      if (res.present) begin
        for (k = slot; k + 1 < list_count; k++) list_store[k] = list_store[k + 1];
        list_count--;
        res.status = STAT_OK;
      end else begin
        res.status = STAT_NOTFOUND;
      end
    end else begin
      res.status = res.present ? STAT_OK : STAT_NOTFOUND;
    end
    res.count = 5'(list_count);
    return res;
  endfunction

  task automatic send_word(cmd_t c, logic [4:0] pos, logic [31:0] v, logic typed,
                           list_result_t typed_result);
    list_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 40'({$urandom(), $urandom()});
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, v, pos, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_list_command(c, pos, v);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_word();
    int r;
    cmd_t c;
    logic [4:0] pos;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (growing) begin
      c = r < 55 ? CMD_INSERT : r < 75 ? CMD_REMOVE : r < 93 ? CMD_LOOKUP : CMD_SPARE;
    end else begin
      c = r < 15 ? CMD_INSERT : r < 65 ? CMD_REMOVE : r < 93 ? CMD_LOOKUP : CMD_SPARE;
    end
    if (c == CMD_INSERT && $urandom_range(0, 9) < 8) pos = 5'($urandom_range(0, list_count));
    else pos = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 85) v = value_pool[$urandom_range(0, PoolSize - 1)];
    else v = $urandom();
    send_word(c, pos, v, 1'b0, '0);
    // Alternate between filling the list up to full and draining it back down.
    if (list_count == Capacity && $urandom_range(0, 5) == 0) growing = 1'b0;
    if (list_count == 0 || $urandom_range(0, 199) == 0) growing = 1'b1;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command outstanding: %h", out_tdata);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[2:0] != exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_tdata[2:0]);
          mismatch_count++;
        end
        if (out_tdata[3] != exp_res.present) begin
          $error("was_present: expected %0d, got %0d", exp_res.present, out_tdata[3]);
          mismatch_count++;
        end
        if (out_tdata[8:4] != exp_res.count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.count, out_tdata[8:4]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase;
    int n;
    foreach (list_store[i]) list_store[i] = '0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (n = 5; n < PoolSize; n++) value_pool[n] = $urandom();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    stall_pct = 36;
    foreach (DirectedRows[i]) begin
      send_word(DirectedRows[i].cmd, DirectedRows[i].pos, DirectedRows[i].value,
                DirectedRows[i].typed, DirectedRows[i].result);
    end
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 88 : 36) : 0;
      stall_pct     = (phase == 2 || phase == 3) ? (phase == 2 ? 88 : 36) : 0;
      for (n = 0; n < ItemsPerPhase; n++) begin
        send_random_word();
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
